FILE: rtl/core/qpdt_pkg.sv
`default_nettype none

package qpdt_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned PROD_W  = 2 * DATA_W;
    localparam int unsigned ERR_W   = PROD_W + 2;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned LIM_W   = 15;
    localparam int unsigned PTERM_W = (GAIN_W + 2) + ERR_W;
    localparam int unsigned DTERM_W = (GAIN_W + 1) + DATA_W;
    localparam int unsigned ACC_W   = PTERM_W + 2;
    localparam int unsigned RND_SHIFT = 26;
    localparam int unsigned KD_ALIGN  = 18;
    localparam int unsigned QUO_W   = ACC_W - RND_SHIFT;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'sd1 <<< (RND_SHIFT - 1));
    localparam logic [LIM_W-1:0] TORQUE_LIMIT_RST = 15'd20972;

    typedef enum logic [1:0] {
        CFG_KP  = 2'd0,
        CFG_KD  = 2'd1,
        CFG_LIM = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [ERR_W-1:0] x;
        logic signed [ERR_W-1:0] y;
        logic signed [ERR_W-1:0] z;
        logic signed [ERR_W-1:0] w;
    } t_quat_err;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]  lim;
    } t_gains;

endpackage

`default_nettype wire

FILE: rtl/core/qpdt_quat_err.sv
`default_nettype none

// Two stages: sixteen 16x16 products, then the four Hamilton sums of
// conj(current) * target, kept exact.
module qpdt_quat_err (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire qpdt_pkg::t_quat   i_curr,
    input  wire qpdt_pkg::t_quat   i_targ,
    output qpdt_pkg::t_quat_err    o_err
);

    logic signed [qpdt_pkg::PROD_W-1:0] r_prod [16];
    logic signed [qpdt_pkg::DATA_W-1:0] cx, cy, cz, cw, tx, ty, tz, tw;
    qpdt_pkg::t_quat_err r_err;

    function automatic logic signed [qpdt_pkg::ERR_W-1:0] ext(
        input logic signed [qpdt_pkg::PROD_W-1:0] v
    );
        return {{(qpdt_pkg::ERR_W - qpdt_pkg::PROD_W){v[qpdt_pkg::PROD_W-1]}}, v};
    endfunction

    always_comb begin
        cx = $signed(i_curr.x);
        cy = $signed(i_curr.y);
        cz = $signed(i_curr.z);
        cw = $signed(i_curr.w);
        tx = $signed(i_targ.x);
        ty = $signed(i_targ.y);
        tz = $signed(i_targ.z);
        tw = $signed(i_targ.w);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0]  <= cw * tw;
            r_prod[1]  <= cx * tx;
            r_prod[2]  <= cy * ty;
            r_prod[3]  <= cz * tz;
            r_prod[4]  <= cw * tx;
            r_prod[5]  <= cx * tw;
            r_prod[6]  <= cy * tz;
            r_prod[7]  <= cz * ty;
            r_prod[8]  <= cw * ty;
            r_prod[9]  <= cx * tz;
            r_prod[10] <= cy * tw;
            r_prod[11] <= cz * tx;
            r_prod[12] <= cw * tz;
            r_prod[13] <= cx * ty;
            r_prod[14] <= cy * tx;
            r_prod[15] <= cz * tw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err.w <= ext(r_prod[0]) + ext(r_prod[1]) + ext(r_prod[2]) + ext(r_prod[3]);
            r_err.x <= ext(r_prod[4]) - ext(r_prod[5]) - ext(r_prod[6]) + ext(r_prod[7]);
            r_err.y <= ext(r_prod[8]) + ext(r_prod[9]) - ext(r_prod[10]) - ext(r_prod[11]);
            r_err.z <= ext(r_prod[12]) - ext(r_prod[13]) + ext(r_prod[14]) - ext(r_prod[15]);
        end
    end

    assign o_err = r_err;

endmodule

`default_nettype wire

FILE: rtl/core/qpdt_axis.sv
`default_nettype none

// Three stages for one axis: gain products, rounding sum, clamp.
module qpdt_axis (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic                                i_flip,
    input  wire logic signed [qpdt_pkg::ERR_W-1:0]   i_err,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_rate,
    input  wire qpdt_pkg::t_gains                    i_gains,
    output logic signed [qpdt_pkg::DATA_W-1:0]       o_torque,
    output logic                                     o_clamped
);

    logic signed [qpdt_pkg::GAIN_W+1:0]  n_gain;
    logic signed [qpdt_pkg::GAIN_W:0]    kd_s;
    logic signed [qpdt_pkg::PTERM_W-1:0] r_p;
    logic signed [qpdt_pkg::DTERM_W-1:0] r_d;
    logic signed [qpdt_pkg::ACC_W-1:0]   n_acc;
    logic signed [qpdt_pkg::QUO_W-1:0]   r_q;
    logic signed [qpdt_pkg::QUO_W-1:0]   lim_pos;
    logic signed [qpdt_pkg::QUO_W-1:0]   lim_neg;
    logic signed [qpdt_pkg::DATA_W-1:0]  n_torque;
    logic                                n_clamped;
    logic signed [qpdt_pkg::DATA_W-1:0]  r_torque;
    logic                                r_clamped;

    // The shortest-path sign flip is folded into the gain, which is cheaper
    // than negating the wide error term.
    always_comb begin
        n_gain = i_flip ? -$signed({2'b00, i_gains.kp}) : $signed({2'b00, i_gains.kp});
        kd_s   = $signed({1'b0, i_gains.kd});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_gain * i_err;
            r_d <= kd_s * i_rate;
        end
    end

    always_comb begin
        n_acc = $signed({r_p[qpdt_pkg::PTERM_W-1], r_p, 1'b0})
              - $signed({{(qpdt_pkg::ACC_W - qpdt_pkg::DTERM_W - qpdt_pkg::KD_ALIGN)
                          {r_d[qpdt_pkg::DTERM_W-1]}},
                         r_d, {qpdt_pkg::KD_ALIGN{1'b0}}})
              + qpdt_pkg::RND_BIAS;
    end

    // Taking the top bits of the two's complement sum is a floor division.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_acc[qpdt_pkg::ACC_W-1:qpdt_pkg::RND_SHIFT];
        end
    end

    always_comb begin
        lim_pos   = $signed({{(qpdt_pkg::QUO_W - qpdt_pkg::LIM_W){1'b0}}, i_gains.lim});
        lim_neg   = -lim_pos;
        n_torque  = r_q[qpdt_pkg::DATA_W-1:0];
        n_clamped = 1'b0;
        if (r_q > lim_pos) begin
            n_torque  = lim_pos[qpdt_pkg::DATA_W-1:0];
            n_clamped = 1'b1;
        end else if (r_q < lim_neg) begin
            n_torque  = lim_neg[qpdt_pkg::DATA_W-1:0];
            n_clamped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_torque  <= n_torque;
            r_clamped <= n_clamped;
        end
    end

    assign o_torque  = r_torque;
    assign o_clamped = r_clamped;

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_pd_torque_core.sv
// Quaternion PD attitude controller.
// Input channel: i_in_valid / o_in_stall carry one item of current and target
// attitude (Q1.15, scalar last) and body rates (Q3.12 rad/s). An item is taken
// on a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry the three clamped torques
// (LSB 2^-20 N*m) and the clamp mask; a result leaves on an edge with
// o_out_valid high and i_out_stall low.
// The stages from acceptance to o_out_valid are two for the
// error quaternion, one for the gain multipliers, one for the rounding add
// and one for the clamp. One item can enter every cycle unless the receiver stalls.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_stall is raised; nothing is dropped or repeated.
// Gains and the torque limit are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the block is idle, and the block does not enforce this. Reset
// (synchronous, active low) empties the pipeline, clears both gains and sets the limit to 20972 (about 0.02 N*m).
`default_nettype none

module quaternion_pd_torque_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_idx,
    input  wire logic [qpdt_pkg::GAIN_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_curr_x,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_curr_y,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_curr_z,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_curr_w,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_targ_x,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_targ_y,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_targ_z,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_targ_w,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_rate_x,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_rate_y,
    input  wire logic signed [qpdt_pkg::DATA_W-1:0]  i_rate_z,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [qpdt_pkg::DATA_W-1:0]      o_torque_x,
    output logic signed [qpdt_pkg::DATA_W-1:0]      o_torque_y,
    output logic signed [qpdt_pkg::DATA_W-1:0]      o_torque_z,
    output logic [2:0]                               o_clamp_mask
);

    localparam int unsigned NUM_STAGES = 5;

    qpdt_pkg::t_gains    r_gains;
    qpdt_pkg::t_quat     curr;
    qpdt_pkg::t_quat     targ;
    qpdt_pkg::t_quat_err err;
    logic [NUM_STAGES-1:0] r_vld;
    logic                  en;
    logic                  flip;

    logic signed [qpdt_pkg::DATA_W-1:0] r_rate_d1 [3];
    logic signed [qpdt_pkg::DATA_W-1:0] r_rate_d2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp  <= '0;
            r_gains.kd  <= '0;
            r_gains.lim <= qpdt_pkg::TORQUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qpdt_pkg::CFG_KP:  r_gains.kp  <= i_cfg_data;
                qpdt_pkg::CFG_KD:  r_gains.kd  <= i_cfg_data;
                qpdt_pkg::CFG_LIM: r_gains.lim <= i_cfg_data[qpdt_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances as a whole unless a finished result is held.
    assign en         = !(r_vld[NUM_STAGES-1] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_in_valid};
        end
    end

    always_comb begin
        curr.x = i_curr_x;
        curr.y = i_curr_y;
        curr.z = i_curr_z;
        curr.w = i_curr_w;
        targ.x = i_targ_x;
        targ.y = i_targ_y;
        targ.z = i_targ_z;
        targ.w = i_targ_w;
    end

    // Rates travel beside the two error-quaternion stages.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rate_d1[0] <= i_rate_x;
            r_rate_d1[1] <= i_rate_y;
            r_rate_d1[2] <= i_rate_z;
            r_rate_d2    <= r_rate_d1;
        end
    end

    qpdt_quat_err u_quat_err (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_curr (curr),
        .i_targ (targ),
        .o_err  (err)
    );

    assign flip = err.w[qpdt_pkg::ERR_W-1];

    qpdt_axis u_axis_x (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_flip    (flip),
        .i_err     (err.x),
        .i_rate    (r_rate_d2[0]),
        .i_gains   (r_gains),
        .o_torque  (o_torque_x),
        .o_clamped (o_clamp_mask[0])
    );

    qpdt_axis u_axis_y (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_flip    (flip),
        .i_err     (err.y),
        .i_rate    (r_rate_d2[1]),
        .i_gains   (r_gains),
        .o_torque  (o_torque_y),
        .o_clamped (o_clamp_mask[1])
    );

    qpdt_axis u_axis_z (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_flip    (flip),
        .i_err     (err.z),
        .i_rate    (r_rate_d2[2]),
        .i_gains   (r_gains),
        .o_torque  (o_torque_z),
        .o_clamped (o_clamp_mask[2])
    );

    assign o_out_valid = r_vld[NUM_STAGES-1];

endmodule

`default_nettype wire
